// ===== rtl/srbs_pkg.sv =====
// Shared types, codes and defaults for the SPI register and buffer slave.
`default_nettype none
package srbs_pkg;

	localparam int REG_COUNT_DEF    = 64;
	localparam int BUFFER_DEPTH_DEF = 128;

	localparam logic [7:0] CMD_REG_BIT   = 8'h80;
	localparam logic [7:0] CMD_WR_BIT    = 8'h40;
	localparam logic [7:0] CMD_BUF_RD    = 8'h00;
	localparam logic [7:0] CMD_BUF_WR    = 8'h40;
	localparam logic [7:0] CMD_FRAME_RD  = 8'h20;
	localparam logic [7:0] CMD_ADDR_MASK = 8'h3F;

	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_REG_RD   = 3'd1;
	localparam logic [2:0] KIND_REG_WR   = 3'd2;
	localparam logic [2:0] KIND_BUF_RD   = 3'd3;
	localparam logic [2:0] KIND_BUF_WR   = 3'd4;
	localparam logic [2:0] KIND_FRAME_RD = 3'd5;

	typedef struct packed {
		logic capture;
		logic ld_addr;
		logic clr_ptr;
		logic ld_ofs;
		logic inc_ptr;
		logic wr_reg;
		logic wr_buf;
		logic resp_reg;
		logic resp_buf;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       frame;
		logic [2:0] kind;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/srbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/srbs_ctrl.sv =====
// Controller: per-byte sequencing and SPI command phase tracking.
`default_nettype none
module srbs_ctrl
	import srbs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd,
	output logic           busy,
	output logic           done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_REG_RD     = 3'd1;
	localparam logic [2:0] PH_REG_WR     = 3'd2;
	localparam logic [2:0] PH_BUF_RD_OFS = 3'd3;
	localparam logic [2:0] PH_BUF_WR_OFS = 3'd4;
	localparam logic [2:0] PH_BUF_RD     = 3'd5;
	localparam logic [2:0] PH_BUF_WR     = 3'd6;

	logic [1:0] state_q, state_d;
	logic [2:0] phase_q, phase_d;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
				if (stat.frame) begin
					case (stat.kind)
						KIND_REG_RD: begin
							cmd.ld_addr = 1'b1;
							phase_d     = PH_REG_RD;
						end
						KIND_REG_WR: begin
							cmd.ld_addr = 1'b1;
							phase_d     = PH_REG_WR;
						end
						KIND_BUF_RD:   phase_d = PH_BUF_RD_OFS;
						KIND_BUF_WR:   phase_d = PH_BUF_WR_OFS;
						KIND_FRAME_RD: begin
							cmd.clr_ptr = 1'b1;
							phase_d     = PH_BUF_RD;
						end
						default:       phase_d = PH_IDLE;
					endcase
				end else begin
					case (phase_q)
						PH_REG_RD: begin
							cmd.resp_reg = 1'b1;
							phase_d      = PH_IDLE;
						end
						PH_REG_WR: begin
							cmd.wr_reg = 1'b1;
							phase_d    = PH_IDLE;
						end
						PH_BUF_RD_OFS: begin
							cmd.ld_ofs = 1'b1;
							phase_d    = PH_BUF_RD;
						end
						PH_BUF_WR_OFS: begin
							cmd.ld_ofs = 1'b1;
							phase_d    = PH_BUF_WR;
						end
						PH_BUF_RD: begin
							cmd.resp_buf = 1'b1;
							cmd.inc_ptr  = 1'b1;
						end
						PH_BUF_WR: begin
							cmd.wr_buf  = 1'b1;
							cmd.inc_ptr = 1'b1;
						end
						default: phase_d = PH_IDLE;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/srbs_dp.sv =====
// Datapath: byte capture, address and pointer registers, register file and frame buffer.
`default_nettype none
module srbs_dp
	import srbs_pkg::*;
#(
	parameter int REG_COUNT    = REG_COUNT_DEF,
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] mosi_byte,
	input  wire logic       frame_start,
	input  wire ctrl_cmd_t  cmd,
	output dp_stat_t        stat,
	output logic      [7:0] miso_byte,
	output logic            read_valid
);

	localparam int RA_W  = $clog2(REG_COUNT);
	localparam int BP_W  = $clog2(BUFFER_DEPTH);
	localparam int RECIP = (65536 + BUFFER_DEPTH - 1) / BUFFER_DEPTH;

	logic [7:0]              byte_q;
	logic                    frame_q;
	logic [5:0]              reg_address_q;
	logic [BP_W-1:0]         ptr_q;
	logic [7:0]              quot_q;
	logic [REG_COUNT-1:0]    reg_valid_q;
	logic [BUFFER_DEPTH-1:0] buf_valid_q;
	logic                    reg_rvld_q;
	logic                    buf_rvld_q;
	logic [7:0]              reg_rdata;
	logic [7:0]              buf_rdata;
	logic [RA_W-1:0]         reg_idx;
	logic                    reg_in_range;
	logic                    reg_we;
	logic [24:0]             quot_prod;
	logic [15:0]             ofs_full;
	logic [BP_W-1:0]         ptr_next;

	assign reg_idx      = reg_address_q[RA_W-1:0];
	assign reg_in_range = {1'b0, reg_address_q} < 7'(REG_COUNT);
	assign reg_we       = cmd.wr_reg && reg_in_range;
	assign quot_prod    = 25'(byte_q) * 25'(RECIP);
	assign ofs_full     = 16'(byte_q) - 16'(quot_q) * 16'(BUFFER_DEPTH);
	assign ptr_next     = (ptr_q == BP_W'(BUFFER_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

	always_comb begin
		stat.frame = frame_q;
		if ((byte_q & CMD_REG_BIT) != 8'h00) begin
			stat.kind = ((byte_q & CMD_WR_BIT) != 8'h00) ? KIND_REG_WR : KIND_REG_RD;
		end else if (byte_q == CMD_BUF_RD) begin
			stat.kind = KIND_BUF_RD;
		end else if (byte_q == CMD_BUF_WR) begin
			stat.kind = KIND_BUF_WR;
		end else if (byte_q == CMD_FRAME_RD) begin
			stat.kind = KIND_FRAME_RD;
		end else begin
			stat.kind = KIND_NONE;
		end
	end

	always_comb begin
		miso_byte  = 8'h00;
		read_valid = 1'b0;
		if (cmd.resp_reg) begin
			read_valid = 1'b1;
			if (reg_in_range && reg_rvld_q) begin
				miso_byte = reg_rdata;
			end
		end else if (cmd.resp_buf) begin
			read_valid = 1'b1;
			if (buf_rvld_q) begin
				miso_byte = buf_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q  <= mosi_byte;
			frame_q <= frame_start;
		end
		quot_q     <= quot_prod[23:16];
		reg_rvld_q <= reg_valid_q[reg_idx];
		buf_rvld_q <= buf_valid_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_address_q <= '0;
			ptr_q         <= '0;
			reg_valid_q   <= '0;
			buf_valid_q   <= '0;
		end else begin
			if (cmd.ld_addr) begin
				reg_address_q <= 6'(byte_q & CMD_ADDR_MASK);
			end
			if (cmd.clr_ptr) begin
				ptr_q <= '0;
			end else if (cmd.ld_ofs) begin
				ptr_q <= ofs_full[BP_W-1:0];
			end else if (cmd.inc_ptr) begin
				ptr_q <= ptr_next;
			end
			if (reg_we) begin
				reg_valid_q[reg_idx] <= 1'b1;
			end
			if (cmd.wr_buf) begin
				buf_valid_q[ptr_q] <= 1'b1;
			end
		end
	end

	srbs_ram #(
		.WIDTH(8),
		.DEPTH(REG_COUNT)
	) u_reg_ram (
		.clk  (clk),
		.we   (reg_we),
		.waddr(reg_idx),
		.wdata(byte_q),
		.raddr(reg_idx),
		.rdata(reg_rdata)
	);

	srbs_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_buf_ram (
		.clk  (clk),
		.we   (cmd.wr_buf),
		.waddr(ptr_q),
		.wdata(byte_q),
		.raddr(ptr_q),
		.rdata(buf_rdata)
	);

endmodule
`default_nettype wire

// ===== rtl/spi_register_and_buffer_slave_top.sv =====
// Top level of the SPI register and buffer slave.
// Each SPI byte is one transaction: start with busy low accepts mosi_byte and frame_start,
// busy then stays high through the READ and DONE states, and done pulses for one cycle in
// the DONE state with miso_byte and read_valid; a new byte is taken only once busy is low
// again. The READ state covers the registered read of the register file and frame buffer
// RAMs, and the DONE state then commits writes and pointer updates. The receiver
// cannot stall done. Both memories read as zero after reset through per-entry valid flags,
// so no clearing pass is needed and the block is ready right out of reset.
`default_nettype none
module spi_register_and_buffer_slave_top
	import srbs_pkg::*;
#(
	parameter int REG_COUNT    = REG_COUNT_DEF,
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] mosi_byte,
	input  wire logic       frame_start,
	output logic            done,
	output logic      [7:0] miso_byte,
	output logic            read_valid
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	srbs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	srbs_dp #(
		.REG_COUNT   (REG_COUNT),
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.mosi_byte  (mosi_byte),
		.frame_start(frame_start),
		.cmd        (cmd),
		.stat       (stat),
		.miso_byte  (miso_byte),
		.read_valid (read_valid)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("done missing two cycles after accepted transaction");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (busy && $past(busy)))
		else $error("done without a transaction in flight");

	a_quiet_out: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (miso_byte == 8'h00 && !read_valid))
		else $error("result ports active outside done");

endmodule
`default_nettype wire
